@@ rtl/bssd_pkg.sv @@
// ----------------------------------------------------------------------------
// bssd_pkg
// Shared types, constants and the crc-6 column table for the position frame
// decoder.
// ----------------------------------------------------------------------------
package bssd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned AngleW  = 26;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CrcW    = 6;
  localparam int unsigned ResW    = 3;
  localparam int unsigned PosMaxW = 21;
  localparam int unsigned ProdW   = PosMaxW + AngleW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CrcW-1:0]    CrcPolyLow     = 6'h03;
  localparam logic [AngleW-1:0]  AngleFullScale = 26'd36000000;
  localparam logic [CountW-1:0]  CountMax       = 16'hFFFF;

  localparam logic               ModeBiss = 1'b0;
  localparam logic               ModeSsi  = 1'b1;

  localparam logic [ResW-1:0]    Res17 = 3'd0;
  localparam logic [ResW-1:0]    Res18 = 3'd1;
  localparam logic [ResW-1:0]    Res19 = 3'd2;
  localparam logic [ResW-1:0]    Res20 = 3'd3;
  localparam logic [ResW-1:0]    Res21 = 3'd4;

  localparam logic [CountW-1:0]  CrcFailLimitRst = 16'd2;
  localparam logic [CountW-1:0]  StuckLimitRst   = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROTOCOL_MODE   = 2'd0,
    CFG_RESOLUTION_CODE = 2'd1,
    CFG_CRC_FAIL_LIMIT  = 2'd2,
    CFG_STUCK_LIMIT     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic crc_ok;
    logic warn;
    logic err;
    logic all_ones;
  } calc_flags_t;

  // column i holds x^(i+6) mod p: the crc contribution of data bit i
  function automatic logic [WordW-1:0][CrcW-1:0] crc6_cols();
    logic [WordW-1:0][CrcW-1:0] cols;
    logic [CrcW-1:0]            r;
    logic                       msb;
    r = 6'h01;
    for (int k = 0; k < CrcW; k++) begin
      msb = r[CrcW-1];
      r   = {r[CrcW-2:0], 1'b0} ^ (msb ? CrcPolyLow : '0);
    end
    for (int i = 0; i < WordW; i++) begin
      cols[i] = r;
      msb     = r[CrcW-1];
      r       = {r[CrcW-2:0], 1'b0} ^ (msb ? CrcPolyLow : '0);
    end
    return cols;
  endfunction

  localparam logic [WordW-1:0][CrcW-1:0] CrcCols = crc6_cols();

endpackage

@@ rtl/biss_ssi_position_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// biss_ssi_position_frame_decoder
// BiSS crc-6 frame check and SSI position scaling with error supervision.
// an input beat passes the input reg, then the result reg, to become a result beat
// throughput: one beat per cycle while the output is not stalled, set by the single-pass crc and multiply stage
// a result waiting at the output still lets one more input beat in
// reset: synchronous active-low rst_n clears valids, counters, flag and
// restores the register defaults
// ----------------------------------------------------------------------------
module biss_ssi_position_frame_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bssd_pkg::WordW-1:0]   in_frame_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bssd_pkg::AngleW-1:0]  out_angle_scaled,
  output logic                         out_crc_ok,
  output logic                         out_warn_bit,
  output logic                         out_error_bit,
  output logic                         out_link_fault,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bssd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bssd_pkg::CfgDatW-1:0] cfg_data
);
  import bssd_pkg::*;

  logic               protocol_mode_r;
  logic [ResW-1:0]    resolution_code_r;
  logic [CountW-1:0]  crc_fail_limit_r;
  logic [CountW-1:0]  stuck_limit_r;

  logic               s1_valid_r;
  logic [WordW-1:0]   s1_word_r;
  logic               s1_adv;

  logic [CountW-1:0]  crc_fail_count_r, crc_fail_count_nxt;
  logic [CountW-1:0]  stuck_count_r, stuck_count_nxt;
  logic               link_fault_r, link_fault_nxt;

  logic [AngleW-1:0]  angle;
  calc_flags_t        flags;

  logic               out_valid_r;
  logic [AngleW-1:0]  angle_r;
  calc_flags_t        flags_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r   <= ModeBiss;
      resolution_code_r <= Res17;
      crc_fail_limit_r  <= CrcFailLimitRst;
      stuck_limit_r     <= StuckLimitRst;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PROTOCOL_MODE:   protocol_mode_r   <= cfg_data[0];
        CFG_RESOLUTION_CODE: resolution_code_r <= cfg_data[ResW-1:0];
        CFG_CRC_FAIL_LIMIT:  crc_fail_limit_r  <= cfg_data;
        CFG_STUCK_LIMIT:     stuck_limit_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_frame_word;
    end
  end

  bssd_calc u_calc (
    .frame_word      (s1_word_r),
    .protocol_mode   (protocol_mode_r),
    .resolution_code (resolution_code_r),
    .angle           (angle),
    .flags           (flags)
  );

  always_comb begin
    crc_fail_count_nxt = crc_fail_count_r;
    stuck_count_nxt    = stuck_count_r;
    link_fault_nxt     = link_fault_r;
    if (protocol_mode_r == ModeBiss) begin
      if (!flags.crc_ok) begin
        if (crc_fail_count_r != CountMax) begin
          crc_fail_count_nxt = crc_fail_count_r + CountW'(1);
        end
        link_fault_nxt = (crc_fail_count_nxt > crc_fail_limit_r);
      end
    end else if (flags.all_ones) begin
      if (stuck_count_r != CountMax) begin
        stuck_count_nxt = stuck_count_r + CountW'(1);
      end
      if (stuck_count_nxt > stuck_limit_r) begin
        link_fault_nxt = 1'b1;
      end
    end else begin
      stuck_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_fail_count_r <= '0;
      stuck_count_r    <= '0;
      link_fault_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (s1_valid_r && s1_adv) begin
        crc_fail_count_r <= crc_fail_count_nxt;
        stuck_count_r    <= stuck_count_nxt;
        link_fault_r     <= link_fault_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      angle_r <= angle;
      flags_r <= flags;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_angle_scaled = angle_r;
  assign out_crc_ok       = flags_r.crc_ok;
  assign out_warn_bit     = flags_r.warn;
  assign out_error_bit    = flags_r.err;
  assign out_link_fault   = link_fault_r;

endmodule

@@ rtl/bssd_calc.sv @@
// ----------------------------------------------------------------------------
// bssd_calc
// Frame split, crc-6 check and angle scaling for one registered frame word.
// ----------------------------------------------------------------------------
module bssd_calc (
  input  logic [bssd_pkg::WordW-1:0]  frame_word,
  input  logic                        protocol_mode,
  input  logic [bssd_pkg::ResW-1:0]   resolution_code,
  output logic [bssd_pkg::AngleW-1:0] angle,
  output bssd_pkg::calc_flags_t       flags
);
  import bssd_pkg::*;

  logic [ResW-1:0]    code;
  logic [PosMaxW-1:0] mask;
  logic [PosMaxW-1:0] pos;
  logic [WordW-1:0]   crc_data;
  logic [CrcW-1:0]    crc_calc;
  logic [ProdW-1:0]   prod;
  logic               crc_match;

  always_comb begin
    code = (resolution_code > Res21) ? Res21 : resolution_code;
    if (protocol_mode == ModeBiss && code == Res21) begin
      code = Res20;
    end
  end

  always_comb begin
    case (code)
      Res17:   mask = 21'h01FFFF;
      Res18:   mask = 21'h03FFFF;
      Res19:   mask = 21'h07FFFF;
      Res20:   mask = 21'h0FFFFF;
      default: mask = 21'h1FFFFF;
    endcase
  end

  assign pos = (protocol_mode == ModeBiss) ? (frame_word[PosMaxW+7:8] & mask)
                                           : (frame_word[PosMaxW-1:0] & mask);

  assign crc_data = {9'd0, pos, frame_word[7], frame_word[6]};

  always_comb begin
    crc_calc = '0;
    for (int i = 0; i < WordW; i++) begin
      crc_calc = crc_calc ^ (crc_data[i] ? CrcCols[i] : '0);
    end
  end

  assign crc_match = (frame_word[CrcW-1:0] == ~crc_calc);

  assign prod = ProdW'(pos) * ProdW'(AngleFullScale);

  always_comb begin
    case (code)
      Res17:   angle = prod[42:17];
      Res18:   angle = prod[43:18];
      Res19:   angle = prod[44:19];
      Res20:   angle = prod[45:20];
      default: angle = prod[46:21];
    endcase
    if (protocol_mode == ModeBiss && !crc_match) begin
      angle = '0;
    end
  end

  always_comb begin
    flags.crc_ok   = (protocol_mode == ModeSsi) || crc_match;
    flags.warn     = (protocol_mode == ModeBiss) && frame_word[6];
    flags.err      = (protocol_mode == ModeBiss) && frame_word[7];
    flags.all_ones = (protocol_mode == ModeSsi) && (pos == mask);
  end

endmodule

@@ rtl/bssd_checker.sv @@
// ----------------------------------------------------------------------------
// bssd_checker
// Port-level checks on the position frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bssd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bssd_pkg::AngleW-1:0]  out_angle_scaled,
  input logic                         out_crc_ok,
  input logic                         out_link_fault
);
  import bssd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_scaled)
      && $stable(out_link_fault))
    else $error("result beat dropped or changed while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_fail_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_crc_ok |-> out_angle_scaled == '0)
    else $error("nonzero angle on crc failure");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_scaled < AngleFullScale)
    else $error("angle beyond full scale");

endmodule

bind biss_ssi_position_frame_decoder bssd_checker u_bssd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_angle_scaled (out_angle_scaled),
  .out_crc_ok       (out_crc_ok),
  .out_link_fault   (out_link_fault)
);
